>>> rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared widths and defaults for the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int DATA_W        = 32;
	localparam int GROUP_SIZE_W  = 5;
	localparam int MAX_GROUP_DEF = 16;

	localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = GROUP_SIZE_W'(1);

endpackage

>>> rtl/stream_group_reverser.sv
// ----------------------------------------------------------------------------
// stream_group_reverser
// Collects a stream of signed beats into groups and replays each complete
// group newest first; a partial group closed by the end marker plays in order.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with item_value and stream_end.
// Output channel: out_valid/out_stall with out_value and run_last.
// The user writes group_size through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block does not enforce this. A value of zero acts as
// one; values above MAX_GROUP act as MAX_GROUP. Every beat is written into
// a one-port-write, registered-read group memory. A beat that neither
// completes a group nor carries stream_end gives nothing. A beat that closes
// a run of n beats stalls the input while the run is replayed, one memory
// read per cycle when the output is not stalled. The first result passes
// the read data stage, then the output register. run_last marks the final
// result of each run. With group size k, the block collects k beats, then
// replays them before it takes another beat.
// An output stall holds the output register and the read data stage, and no
// further read is issued until they drain.
// Reset empties the group, drops any replay in progress and sets group_size
// to one. The memory contents are not cleared.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
	parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic        [sgr_pkg::GROUP_SIZE_W-1:0] cfg_wr_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [sgr_pkg::DATA_W-1:0]       item_value,
	input  logic                                    stream_end,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [sgr_pkg::DATA_W-1:0]       out_value,
	output logic                                    run_last
);

	localparam int CNT_W  = $clog2(MAX_GROUP + 1);
	localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CMP_W  = (CNT_W > sgr_pkg::GROUP_SIZE_W) ? CNT_W : sgr_pkg::GROUP_SIZE_W;

	typedef enum logic {
		ST_COLLECT,
		ST_REPLAY
	} state_t;

	state_t                                 state_q;
	logic       [sgr_pkg::GROUP_SIZE_W-1:0] group_size_q;
	logic       [CNT_W-1:0]                 fill_q;
	logic       [CNT_W-1:0]                 rem_q;
	logic       [ADDR_W-1:0]                rd_addr_q;
	logic                                   reverse_q;
	logic                                   pend_s1;
	logic                                   last_s1;
	logic signed [sgr_pkg::DATA_W-1:0]      rd_data_s1;
	logic signed [sgr_pkg::DATA_W-1:0]      group_mem [MAX_GROUP];

	logic              in_accept;
	logic              has_room;
	logic [CMP_W-1:0]  size_w;
	logic [CMP_W-1:0]  k_eff;
	logic [CMP_W-1:0]  n_w;
	logic [CNT_W-1:0]  n_cnt;
	logic              full_group;
	logic              do_flush;
	logic              out_load;
	logic              rd_en;

	// group size clamp and flush decision
	always_comb begin
		size_w = CMP_W'(group_size_q);
		if (size_w == '0) begin
			k_eff = CMP_W'(1);
		end else if (size_w > CMP_W'(MAX_GROUP)) begin
			k_eff = CMP_W'(MAX_GROUP);
		end else begin
			k_eff = size_w;
		end
	end

	assign in_stall   = (state_q != ST_COLLECT);
	assign in_accept  = in_valid && !in_stall;
	assign has_room   = (fill_q < CNT_W'(MAX_GROUP));
	assign n_cnt      = has_room ? fill_q + CNT_W'(1) : fill_q;
	assign n_w        = CMP_W'(n_cnt);
	assign full_group = (n_w >= k_eff);
	assign do_flush   = in_accept && (full_group || stream_end);

	assign out_load = pend_s1 && (!out_valid || !out_stall);
	assign rd_en    = (state_q == ST_REPLAY) && (rem_q != '0) && (!pend_s1 || out_load);

	// group memory
	always_ff @(posedge clk) begin
		if (in_accept && has_room) begin
			group_mem[fill_q[ADDR_W-1:0]] <= item_value;
		end
		if (rd_en) begin
			rd_data_s1 <= group_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= sgr_pkg::GROUP_SIZE_RST;
		end else if (cfg_wr_en) begin
			group_size_q <= cfg_wr_data;
		end
	end

	// sequencer, read tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			fill_q    <= '0;
			rem_q     <= '0;
			rd_addr_q <= '0;
			reverse_q <= 1'b0;
			pend_s1   <= 1'b0;
			last_s1   <= 1'b0;
			out_valid <= 1'b0;
			run_last  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (do_flush) begin
						state_q   <= ST_REPLAY;
						fill_q    <= '0;
						rem_q     <= n_cnt;
						reverse_q <= full_group;
						rd_addr_q <= full_group ? ADDR_W'(n_cnt - CNT_W'(1)) : '0;
					end else if (in_accept) begin
						fill_q <= n_cnt;
					end
				end
				ST_REPLAY: begin
					if (rd_en) begin
						rem_q     <= rem_q - CNT_W'(1);
						rd_addr_q <= reverse_q ? rd_addr_q - ADDR_W'(1)
						                       : rd_addr_q + ADDR_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_COLLECT;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase

			if (rd_en) begin
				pend_s1 <= 1'b1;
				last_s1 <= (rem_q == CNT_W'(1));
			end else if (out_load) begin
				pend_s1 <= 1'b0;
			end

			if (out_load) begin
				out_valid <= 1'b1;
				run_last  <= last_s1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value <= rd_data_s1;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(MAX_GROUP))
		else $error("group fill reached capacity before flush");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && out_valid && out_stall |=> pend_s1 && $stable(rd_data_s1))
		else $error("pending read data lost under output stall");

	a_flush_enters_replay: assert property (@(posedge clk) disable iff (!arst_n)
		do_flush |=> state_q == ST_REPLAY && rem_q != '0 && fill_q == '0)
		else $error("flush did not start a replay");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rem_q <= CNT_W'(MAX_GROUP))
		else $error("replay count beyond group capacity");

endmodule
